// ----- rtl/pcme_pkg.sv -----
// ----------------------------------------------------------------------------
// pcme_pkg
// Shared constants, control word layout and microprogram for the
// partition count residue engine.
// ----------------------------------------------------------------------------
package pcme_pkg;

  localparam int MAX_INDEX_DEF    = 65536;
  localparam int RESIDUE_BITS_DEF = 20;

  localparam int MOD_W   = 21;
  localparam int LIM_W   = 16;
  localparam int IDX_W   = 16;
  localparam int RES_W   = 20;
  localparam int NEXT_W  = 17;
  localparam int CFG_A_W = 1;

  localparam logic [MOD_W-1:0] MOD_RESET   = MOD_W'(1000000);
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(65535);

  localparam logic [CFG_A_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_LIMIT   = 1'b1;

  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [PC_W-1:0] STEP_DISP = 3'd1;
  localparam logic [PC_W-1:0] STEP_LOOP = 3'd2;
  localparam logic [PC_W-1:0] STEP_TERM = 3'd3;
  localparam logic [PC_W-1:0] STEP_DIV  = 3'd4;
  localparam logic [PC_W-1:0] STEP_WB   = 3'd5;
  localparam logic [PC_W-1:0] STEP_EMIT = 3'd6;

  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_DONE,
    COND_MORE,
    COND_FAST_MORE,
    COND_DIV_RUN,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic            ready;
    logic            init;
    logic            issue;
    logic            consume;
    logic            div;
    logic            wb;
    logic            emit;
    cond_e           cond;
    logic [PC_W-1:0] t_true;
    logic [PC_W-1:0] t_false;
  } ctl_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    case (pc)
      STEP_IDLE: begin
        c.ready = 1'b1; c.cond = COND_ACCEPT;
        c.t_true = STEP_DISP; c.t_false = STEP_IDLE;
      end
      STEP_DISP: begin
        c.init = 1'b1; c.cond = COND_DONE;
        c.t_true = STEP_EMIT; c.t_false = STEP_LOOP;
      end
      STEP_LOOP: begin
        c.issue = 1'b1; c.cond = COND_MORE;
        c.t_true = STEP_TERM; c.t_false = STEP_WB;
      end
      STEP_TERM: begin
        c.issue = 1'b1; c.consume = 1'b1; c.cond = COND_FAST_MORE;
        c.t_true = STEP_TERM; c.t_false = STEP_DIV;
      end
      STEP_DIV: begin
        c.div = 1'b1; c.cond = COND_DIV_RUN;
        c.t_true = STEP_DIV; c.t_false = STEP_LOOP;
      end
      STEP_WB: begin
        c.wb = 1'b1; c.cond = COND_OUT_FREE;
        c.t_true = STEP_IDLE; c.t_false = STEP_WB;
      end
      STEP_EMIT: begin
        c.emit = 1'b1; c.cond = COND_OUT_FREE;
        c.t_true = STEP_IDLE; c.t_false = STEP_EMIT;
      end
      default: begin
        c.ready = 1'b1; c.cond = COND_ACCEPT;
        c.t_true = STEP_DISP; c.t_false = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/partition_count_mod_engine.sv -----
// ----------------------------------------------------------------------------
// partition_count_mod_engine
// Computes p(n) mod m with the pentagonal recurrence, one n per request.
// ----------------------------------------------------------------------------
// Each request yields one result. For a fresh n, the residue table has one
// read port, read once per pentagonal offset, and the read of the next
// offset overlaps the add or subtract of the current one. A table entry
// that is not below the current modulus (left from a run under a larger
// modulus) is reduced in the bit-serial remainder unit. The table needs no
// clearing pass after reset; entry 0 lives in its own register.
module partition_count_mod_engine #(
  parameter int MAX_INDEX    = pcme_pkg::MAX_INDEX_DEF,
  parameter int RESIDUE_BITS = pcme_pkg::RESIDUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pcme_pkg::IDX_W-1:0]  out_index_o,
  output logic [pcme_pkg::RES_W-1:0]  out_residue_o,
  output logic                        out_divisible_o,
  output logic                        out_finished_o,
  input  logic                        cfg_we_i,
  input  logic [pcme_pkg::CFG_A_W-1:0] cfg_index_i,
  input  logic [pcme_pkg::MOD_W-1:0]  cfg_wdata_i
);

  localparam int RB   = RESIDUE_BITS;
  localparam int AW   = $clog2(MAX_INDEX);
  localparam int OW   = AW + 1;
  localparam int CW   = (pcme_pkg::MOD_W > RB + 1) ? pcme_pkg::MOD_W : RB + 1;
  localparam int NXW  = (pcme_pkg::NEXT_W > AW + 1) ? pcme_pkg::NEXT_W : AW + 1;
  localparam int LW   = (AW > pcme_pkg::LIM_W) ? AW : pcme_pkg::LIM_W;
  localparam int IW   = (AW > pcme_pkg::IDX_W) ? AW : pcme_pkg::IDX_W;
  localparam int RW   = (RB > pcme_pkg::RES_W) ? RB : pcme_pkg::RES_W;
  localparam int CNTW = $clog2(RB);

  // config
  logic [pcme_pkg::MOD_W-1:0] mod_q;
  logic [pcme_pkg::LIM_W-1:0] lim_q;

  // sequencer
  logic [pcme_pkg::PC_W-1:0] pc_q, pc_d;
  pcme_pkg::ctl_t            cw;
  logic                      cond_hit;

  // run state
  logic [pcme_pkg::NEXT_W-1:0] next_q;
  logic                        done_q;
  logic [AW-1:0]               n_q;
  logic [OW-1:0]               off_q;
  logic [AW-1:0]               j_q;
  logic [1:0]                  k_q;
  logic [RB-1:0]               acc_q;
  logic [RB-1:0]               zero_q;
  logic [RB-1:0]               rdata_q;
  logic                        rd_zero_q;
  logic                        sign_q;
  logic [pcme_pkg::IDX_W-1:0]  last_idx_q;
  logic [RB-1:0]               last_res_q;

  // remainder unit
  logic            div_busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [RB-1:0]   div_val_q;
  logic [RB-1:0]   rem_q;

  // output register
  logic                       out_valid_q;
  logic [pcme_pkg::IDX_W-1:0] out_index_q;
  logic [pcme_pkg::RES_W-1:0] out_residue_q;
  logic                       out_div_q;
  logic                       out_fin_q;

  logic [RB-1:0] mem [MAX_INDEX];

  // effective modulus
  logic [CW-1:0] mod_ext, mod_cap, mod_sel;
  logic [RB:0]   m_eff;
  assign mod_ext = CW'(mod_q);
  assign mod_cap = CW'(1) << RB;
  assign mod_sel = (mod_ext == '0) ? CW'(1) : ((mod_ext > mod_cap) ? mod_cap : mod_ext);
  assign m_eff   = mod_sel[RB:0];

  assign cw = pcme_pkg::ucode(pc_q);

  logic accept, out_free, more, fast, issue_en, div_last, acc_en;
  assign accept   = cw.ready && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign more     = off_q <= {1'b0, n_q};

  logic [RB-1:0] v;
  assign v    = rd_zero_q ? zero_q : rdata_q;
  assign fast = {1'b0, v} < m_eff;

  assign issue_en = cw.issue && more && (!cw.consume || fast);
  assign div_last = cw.div && div_busy_q && (cnt_q == '0);

  always_comb begin
    case (cw.cond)
      pcme_pkg::COND_ACCEPT:    cond_hit = in_valid_i;
      pcme_pkg::COND_DONE:      cond_hit = done_q;
      pcme_pkg::COND_MORE:      cond_hit = more;
      pcme_pkg::COND_FAST_MORE: cond_hit = fast && more;
      pcme_pkg::COND_DIV_RUN:   cond_hit = div_busy_q && (cnt_q != '0);
      pcme_pkg::COND_OUT_FREE:  cond_hit = out_free;
      default:                  cond_hit = 1'b0;
    endcase
    pc_d = cond_hit ? cw.t_true : cw.t_false;
  end

  // remainder step
  logic [RB:0]   rem_sh, rem_diff;
  logic [RB-1:0] rem_new;
  assign rem_sh   = {rem_q, div_val_q[RB-1]};
  assign rem_diff = rem_sh - m_eff;
  assign rem_new  = (rem_sh >= m_eff) ? rem_diff[RB-1:0] : rem_sh[RB-1:0];

  // modular accumulate
  logic [RB-1:0] tv, acc_d;
  logic [RB:0]   sum, sum_red, dif;
  assign tv      = cw.div ? rem_new : v;
  assign sum     = {1'b0, acc_q} + {1'b0, tv};
  assign sum_red = sum - m_eff;
  assign dif     = (acc_q >= tv) ? ({1'b0, acc_q} - {1'b0, tv})
                                 : ({1'b0, acc_q} + m_eff - {1'b0, tv});
  assign acc_d   = sign_q ? dif[RB-1:0]
                          : ((sum >= m_eff) ? sum_red[RB-1:0] : sum[RB-1:0]);
  assign acc_en  = (cw.consume && fast) || div_last;

  // offset walk
  logic [OW-1:0] step;
  logic [AW-1:0] rd_addr;
  assign step    = k_q[0] ? {j_q, 1'b1} : {1'b0, j_q};
  assign rd_addr = n_q - off_q[AW-1:0];

  // start index and finish test
  logic [NXW-1:0] next_ext, n_plus;
  logic [AW-1:0]  n_init;
  logic           fin;
  assign next_ext = NXW'(next_q);
  assign n_init   = (next_ext >= NXW'(MAX_INDEX)) ? AW'(MAX_INDEX - 1) : next_ext[AW-1:0];
  assign n_plus   = NXW'(n_q) + NXW'(1);
  assign fin      = (acc_q == '0) || (LW'(n_q) >= LW'(lim_q))
                 || (n_q == AW'(MAX_INDEX - 1));

  logic [IW-1:0] n_wide;
  logic [RW-1:0] acc_wide, last_wide;
  assign n_wide    = IW'(n_q);
  assign acc_wide  = RW'(acc_q);
  assign last_wide = RW'(last_res_q);

  logic wb_go, emit_go;
  assign wb_go   = cw.wb && out_free;
  assign emit_go = cw.emit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= pcme_pkg::MOD_RESET;
      lim_q       <= pcme_pkg::LIMIT_RESET;
      pc_q        <= pcme_pkg::STEP_IDLE;
      next_q      <= pcme_pkg::NEXT_W'(1);
      done_q      <= 1'b0;
      zero_q      <= RB'(1);
      div_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcme_pkg::CFG_MODULUS: mod_q <= cfg_wdata_i;
          pcme_pkg::CFG_LIMIT:   lim_q <= cfg_wdata_i[pcme_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (accept && in_restart_i) begin
        zero_q <= RB'(1);
        next_q <= pcme_pkg::NEXT_W'(1);
        done_q <= 1'b0;
      end
      if (cw.consume && !fast) begin
        div_busy_q <= 1'b1;
      end else if (div_last) begin
        div_busy_q <= 1'b0;
      end
      if (wb_go) begin
        if (n_q == '0) zero_q <= acc_q;
        next_q <= n_plus[pcme_pkg::NEXT_W-1:0];
        if (fin) done_q <= 1'b1;
      end
      if (wb_go || emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.init) begin
      n_q   <= n_init;
      off_q <= OW'(1);
      j_q   <= AW'(1);
      k_q   <= 2'd0;
      acc_q <= '0;
    end else if (acc_en) begin
      acc_q <= acc_d;
    end
    if (issue_en) begin
      rdata_q   <= mem[rd_addr];
      rd_zero_q <= (rd_addr == '0);
      sign_q    <= k_q[1];
      off_q     <= off_q + step;
      if (k_q[0]) j_q <= j_q + AW'(1);
      k_q <= k_q + 2'd1;
    end
    if (cw.consume && !fast) begin
      div_val_q <= v;
      rem_q     <= '0;
      cnt_q     <= CNTW'(RB - 1);
    end else if (cw.div && div_busy_q) begin
      div_val_q <= div_val_q << 1;
      rem_q     <= rem_new;
      cnt_q     <= cnt_q - CNTW'(1);
    end
    if (wb_go) begin
      if (n_q != '0) mem[n_q] <= acc_q;
      last_idx_q    <= n_wide[pcme_pkg::IDX_W-1:0];
      last_res_q    <= acc_q;
      out_index_q   <= n_wide[pcme_pkg::IDX_W-1:0];
      out_residue_q <= acc_wide[pcme_pkg::RES_W-1:0];
      out_div_q     <= (acc_q == '0);
      out_fin_q     <= fin;
    end else if (emit_go) begin
      out_index_q   <= last_idx_q;
      out_residue_q <= last_wide[pcme_pkg::RES_W-1:0];
      out_div_q     <= (last_res_q == '0);
      out_fin_q     <= 1'b1;
    end
  end

  assign in_ready_o      = cw.ready;
  assign out_valid_o     = out_valid_q;
  assign out_index_o     = out_index_q;
  assign out_residue_o   = out_residue_q;
  assign out_divisible_o = out_div_q;
  assign out_finished_o  = out_fin_q;

  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy_q)
    else $error("remainder unit busy while idle");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == pcme_pkg::STEP_WB) |-> ({1'b0, acc_q} < m_eff))
    else $error("accumulator not reduced");

  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == pcme_pkg::STEP_WB) |-> !more)
    else $error("write-back before offset walk ended");

  a_div_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_divisible_o) |-> out_finished_o)
    else $error("divisible result not finished");

endmodule
